### src/tick_to_ohlc_bar_aggregator_macros.svh
// Assertion macros shared by the bar aggregator RTL
`ifndef TICK_TO_OHLC_BAR_AGGREGATOR_MACROS_SVH
`define TICK_TO_OHLC_BAR_AGGREGATOR_MACROS_SVH
`ifndef SYNTHESIS
`define TTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tta assertion failed");
`define TTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tta assertion failed");
`else
`define TTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/tta_pkg.sv
// Types and constants for the tick to OHLC bar aggregator
`timescale 1ns / 1ps
package tta_pkg;
    localparam int NUM_FRAMES_DEF  = 4;
    localparam int REG_FRAMES      = 4;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SECS_W          = 12;
    localparam int TIME_W          = 64;
    localparam int PRICE_W         = 32;
    localparam int DELTA_W         = 33;
    localparam int PERIOD_W        = 22;
    localparam int CFG_IDX_W       = 8;
    localparam int MS_PER_SEC      = 1000;
    localparam int AVG_DIVISOR     = 3;

    // floor(x / 3) == (x * AVG_RECIP) >> AVG_SHIFT for any x below 2^35
    localparam int                     AVG_RECIP_W = 34;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP   = 34'h2_AAAA_AAAB;
    localparam int                     AVG_SHIFT   = 35;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_B = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_C = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_D = 8'd3;

    localparam logic [SECS_W-1:0] FRAME_A_RST = 12'd3;
    localparam logic [SECS_W-1:0] FRAME_B_RST = 12'd5;
    localparam logic [SECS_W-1:0] FRAME_C_RST = 12'd10;
    localparam logic [SECS_W-1:0] FRAME_D_RST = 12'd15;

    localparam logic [1:0] DIR_FLAT = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    typedef struct packed {
        logic [TIME_W-1:0]         tick_time_ms;
        logic [PRICE_W-1:0]        last_price;
        logic signed [DELTA_W-1:0] dvol;
        logic signed [DELTA_W-1:0] doi;
    } item_t;
endpackage

### src/tta_if.sv
// Channel interfaces: ticks in, bars out, configuration writes
`timescale 1ns / 1ps
interface tick_if;
    import tta_pkg::*;
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  tick_time_ms;
    logic [PRICE_W-1:0] last_price;
    logic [PRICE_W-1:0] total_volume;
    logic [PRICE_W-1:0] total_interest;
    modport source (output valid, tick_time_ms, last_price, total_volume, total_interest,
                    input ready);
    modport sink (input valid, tick_time_ms, last_price, total_volume, total_interest,
                  output ready);
endinterface

interface bar_if;
    import tta_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                frame_index;
    logic [TIME_W-1:0]         bar_time_ms;
    logic [PRICE_W-1:0]        bar_open;
    logic [PRICE_W-1:0]        bar_high;
    logic [PRICE_W-1:0]        bar_low;
    logic [PRICE_W-1:0]        bar_close;
    logic [PRICE_W-1:0]        bar_average;
    logic signed [1:0]         bar_direction;
    logic signed [DELTA_W-1:0] delta_volume;
    logic signed [DELTA_W-1:0] delta_interest;
    logic signed [DELTA_W-1:0] close_minus_open;
    logic                      last_of_run;
    modport source (output valid, frame_index, bar_time_ms, bar_open, bar_high, bar_low,
                    bar_close, bar_average, bar_direction, delta_volume, delta_interest,
                    close_minus_open, last_of_run, input ready);
    modport sink (input valid, frame_index, bar_time_ms, bar_open, bar_high, bar_low,
                  bar_close, bar_average, bar_direction, delta_volume, delta_interest,
                  close_minus_open, last_of_run, output ready);
endinterface

interface cfg_if;
    import tta_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SECS_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/tick_to_ohlc_bar_aggregator.sv
// Top level: configuration registers, front end, queue and back end
//
//  channel | dir | handshake         | payload
//  tick    | in  | valid/ready       | tick_time_ms, last_price, total_volume, total_interest
//  bar     | out | valid/ready       | frame_index .. last_of_run, one per frame
//  cfg     | in  | valid/ready (rdy=1)| index, data (frame seconds)
//
// Each frame runs on the shared one-bit-per-cycle divider for the floor of the tick time,
// then latches the floor, updates the bar, forms the average by reciprocal multiply in two
// halves and holds the bar in the output registers until bar ready. The first tick after
// reset gives no bars. Reset clears the bar stores to zero at once. The front end keeps
// taking ticks while the queue has room; a stalled bar output holds the back end.
`timescale 1ns / 1ps
module tick_to_ohlc_bar_aggregator #(
    parameter int NUM_FRAMES  = tta_pkg::NUM_FRAMES_DEF,
    parameter int QUEUE_DEPTH = tta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tick_if.sink  tick,
    bar_if.source bar,
    cfg_if.sink   cfg
);
    import tta_pkg::*;

    logic [SECS_W-1:0] frame_secs_reg [REG_FRAMES];
    logic  q_full, q_empty, q_push, q_pop;
    item_t q_item, q_head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_secs_reg[0] <= FRAME_A_RST;
            frame_secs_reg[1] <= FRAME_B_RST;
            frame_secs_reg[2] <= FRAME_C_RST;
            frame_secs_reg[3] <= FRAME_D_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_A: frame_secs_reg[0] <= cfg.data;
                REG_FRAME_B: frame_secs_reg[1] <= cfg.data;
                REG_FRAME_C: frame_secs_reg[2] <= cfg.data;
                REG_FRAME_D: frame_secs_reg[3] <= cfg.data;
                default: ;
            endcase
        end
    end

    tta_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    tta_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head_item (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tta_back #(.NUM_FRAMES(NUM_FRAMES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_secs (frame_secs_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .bar        (bar)
    );
endmodule

### src/tta_front.sv
// Front end: primes on the first tick, turns cumulative values into per-tick differences
`timescale 1ns / 1ps
module tta_front (
    input  logic           clk,
    input  logic           rst_n,
    tick_if.sink           tick,
    input  logic           q_full,
    output logic           q_push,
    output tta_pkg::item_t q_item
);
    import tta_pkg::*;

    logic               primed_reg;
    logic [PRICE_W-1:0] prev_vol_reg;
    logic [PRICE_W-1:0] prev_oi_reg;
    logic               accept;

    assign tick.ready = !q_full;
    assign accept     = tick.valid && tick.ready;
    assign q_push     = accept && primed_reg;

    always_comb
    begin
        q_item.tick_time_ms = tick.tick_time_ms;
        q_item.last_price   = tick.last_price;
        q_item.dvol = $signed({1'b0, tick.total_volume}) - $signed({1'b0, prev_vol_reg});
        q_item.doi  = $signed({1'b0, tick.total_interest}) - $signed({1'b0, prev_oi_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg   <= 1'b0;
            prev_vol_reg <= '0;
            prev_oi_reg  <= '0;
        end
        else if (accept)
        begin
            primed_reg   <= 1'b1;
            prev_vol_reg <= tick.total_volume;
            prev_oi_reg  <= tick.total_interest;
        end
    end
endmodule

### src/tta_fifo.sv
// Short queue between front and back end
`timescale 1ns / 1ps
module tta_fifo #(
    parameter int DEPTH = tta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tta_pkg::item_t push_item,
    input  logic           pop,
    output tta_pkg::item_t head_item,
    output logic           full,
    output logic           empty
);
    import tta_pkg::*;
    `include "tick_to_ohlc_bar_aggregator_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `TTA_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full || pop)
    `TTA_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !empty)
    `TTA_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
endmodule

### src/tta_div.sv
// Restoring divider for the remainder, one bit per cycle
`timescale 1ns / 1ps
module tta_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tta_pkg::TIME_W-1:0]    dividend,
    input  logic [tta_pkg::PERIOD_W-1:0]  divisor,
    output logic                          done,
    output logic [tta_pkg::PERIOD_W-1:0]  remainder
);
    import tta_pkg::*;
    `include "tick_to_ohlc_bar_aggregator_macros.svh"

    localparam int CNT_W = $clog2(TIME_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TIME_W-1:0]   q_reg;
    logic [PERIOD_W-1:0] r_reg;
    logic [PERIOD_W-1:0] d_reg;
    logic [PERIOD_W:0]   shifted;
    logic [PERIOD_W:0]   diff;
    logic                ge;

    assign shifted   = {r_reg, q_reg[TIME_W-1]};
    assign diff      = shifted - {1'b0, d_reg};
    assign ge        = (shifted >= {1'b0, d_reg});
    assign done      = done_reg;
    assign remainder = r_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[TIME_W-2:0], ge};
            r_reg <= ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TIME_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    `TTA_ASSERT_IMP(a_start_idle, clk, rst_n, start, !busy_reg)
    `TTA_ASSERT_NXT(a_done_follows, clk, rst_n, busy_reg && cnt_reg == '0, done_reg && !busy_reg)
    `TTA_ASSERT_IMP(a_done_single, clk, rst_n, done_reg, !busy_reg)
endmodule

### src/tta_back.sv
// Back end: per-frame bar floor, update, average and result register
`timescale 1ns / 1ps
module tta_back #(
    parameter int NUM_FRAMES = tta_pkg::NUM_FRAMES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tta_pkg::SECS_W-1:0] frame_secs [tta_pkg::REG_FRAMES],
    input  logic                       q_empty,
    input  tta_pkg::item_t             q_head,
    output logic                       q_pop,
    bar_if.source                      bar
);
    import tta_pkg::*;
    `include "tick_to_ohlc_bar_aggregator_macros.svh"

    localparam int FRAMES = (NUM_FRAMES > REG_FRAMES) ? REG_FRAMES : NUM_FRAMES;
    localparam int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int HALF_W = (PRICE_W + 2) / 2;
    localparam int PART_W = HALF_W + AVG_RECIP_W;
    localparam int ACC_W  = PRICE_W + 2 + AVG_RECIP_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_AVG  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [FW-1:0] k_reg;
    item_t       item_reg;
    logic [TIME_W-1:0] floored_reg;

    logic [TIME_W-1:0]         start_store [FRAMES];
    logic [PRICE_W-1:0]        open_store  [FRAMES];
    logic [PRICE_W-1:0]        high_store  [FRAMES];
    logic [PRICE_W-1:0]        low_store   [FRAMES];
    logic signed [DELTA_W-1:0] fvol_store  [FRAMES];
    logic signed [DELTA_W-1:0] foi_store   [FRAMES];

    logic [1:0]                o_frame_reg;
    logic [TIME_W-1:0]         o_time_reg;
    logic [PRICE_W-1:0]        o_open_reg, o_high_reg, o_low_reg, o_close_reg, o_avg_reg;
    logic signed [1:0]         o_dir_reg;
    logic signed [DELTA_W-1:0] o_dvol_reg, o_doi_reg, o_com_reg;
    logic                      o_last_reg;

    logic [PRICE_W+1:0]        avg_sum_reg;
    logic [ACC_W-1:0]          avg_acc_reg;
    logic                      avg_ph_reg;
    logic [HALF_W-1:0]         avg_half;
    logic [PART_W-1:0]         avg_part;
    logic [ACC_W-1:0]          avg_total;

    logic                      div_start, div_done;
    logic [TIME_W-1:0]         div_dividend;
    logic [PERIOD_W-1:0]       div_divisor, div_r;
    logic [FW-1:0]             k_sel;
    logic [SECS_W-1:0]         secs;
    logic [PERIOD_W-1:0]       period;
    logic                      is_last, out_take, hit;
    logic [PRICE_W-1:0]        price, new_open, new_high, new_low;
    logic signed [DELTA_W-1:0] new_dvol, new_doi;
    logic signed [DELTA_W:0]   dv_diff, di_diff;
    logic [PRICE_W+1:0]        sum3;

    function automatic logic signed [DELTA_W-1:0] sat33(input logic signed [DELTA_W:0] v);
        logic signed [DELTA_W-1:0] r;
        if (v[DELTA_W] != v[DELTA_W-1])
            r = v[DELTA_W] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
        else
            r = v[DELTA_W-1:0];
        return r;
    endfunction

    assign is_last  = (k_reg == FW'(FRAMES - 1));
    assign out_take = (state_reg == S_OUT) && bar.ready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign price    = item_reg.last_price;

    // frame whose floor division starts this cycle
    assign k_sel  = (state_reg == S_IDLE) ? '0 : k_reg + 1'b1;
    assign secs   = frame_secs[2'(k_sel)];
    assign period = PERIOD_W'((secs == '0) ? SECS_W'(1) : secs) * PERIOD_W'(MS_PER_SEC);

    always_comb
    begin
        hit      = (floored_reg == start_store[k_reg]);
        dv_diff  = (DELTA_W+1)'(item_reg.dvol) - (DELTA_W+1)'(fvol_store[k_reg]);
        di_diff  = (DELTA_W+1)'(item_reg.doi) - (DELTA_W+1)'(foi_store[k_reg]);
        if (hit)
        begin
            new_open = open_store[k_reg];
            new_high = (price > high_store[k_reg]) ? price : high_store[k_reg];
            new_low  = (price < low_store[k_reg]) ? price : low_store[k_reg];
            new_dvol = sat33(dv_diff);
            new_doi  = sat33(di_diff);
        end
        else
        begin
            new_open = price;
            new_high = price;
            new_low  = price;
            new_dvol = item_reg.dvol;
            new_doi  = item_reg.doi;
        end
        sum3 = (PRICE_W+2)'(new_high) + (PRICE_W+2)'(new_low) + (PRICE_W+2)'(price);
    end

    // average by reciprocal multiply, low half of the sum first, high half next
    always_comb
    begin
        avg_half  = avg_ph_reg ? avg_sum_reg[PRICE_W+1:HALF_W] : avg_sum_reg[HALF_W-1:0];
        avg_part  = PART_W'(avg_half) * PART_W'(AVG_RECIP);
        avg_total = avg_acc_reg + {avg_part, HALF_W'(0)};
    end

    always_comb
    begin
        div_start    = q_pop || (out_take && !is_last);
        div_dividend = (state_reg == S_IDLE) ? q_head.tick_time_ms : item_reg.tick_time_ms;
        div_divisor  = period;
    end

    tta_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (!q_empty) state_next = S_MOD;
            S_MOD:  if (div_done) state_next = S_UPD;
            S_UPD:  state_next = S_AVG;
            S_AVG:  if (avg_ph_reg) state_next = S_OUT;
            S_OUT:  if (bar.ready) state_next = is_last ? S_IDLE : S_MOD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_head;
        if (state_reg == S_MOD && div_done)
            floored_reg <= item_reg.tick_time_ms - TIME_W'(div_r);
        if (state_reg == S_UPD)
        begin
            avg_sum_reg <= sum3;
            o_frame_reg <= 2'(k_reg);
            o_time_reg  <= floored_reg;
            o_open_reg  <= new_open;
            o_high_reg  <= new_high;
            o_low_reg   <= new_low;
            o_close_reg <= price;
            o_dvol_reg  <= new_dvol;
            o_doi_reg   <= new_doi;
            o_com_reg   <= (DELTA_W)'(price) - (DELTA_W)'(new_open);
            o_last_reg  <= is_last;
            if (new_open > price)
                o_dir_reg <= DIR_DOWN;
            else if (new_open == price)
                o_dir_reg <= DIR_FLAT;
            else
                o_dir_reg <= DIR_UP;
        end
        if (state_reg == S_AVG && !avg_ph_reg)
            avg_acc_reg <= ACC_W'(avg_part);
        if (state_reg == S_AVG && avg_ph_reg)
            o_avg_reg <= avg_total[AVG_SHIFT+PRICE_W-1:AVG_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            avg_ph_reg <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                start_store[i] <= '0;
                open_store[i]  <= '0;
                high_store[i]  <= '0;
                low_store[i]   <= '0;
                fvol_store[i]  <= '0;
                foi_store[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
                k_reg <= '0;
            else if (out_take && !is_last)
                k_reg <= k_reg + 1'b1;
            if (state_reg == S_UPD)
                avg_ph_reg <= 1'b0;
            else if (state_reg == S_AVG)
                avg_ph_reg <= !avg_ph_reg;
            if (state_reg == S_UPD)
            begin
                high_store[k_reg] <= new_high;
                low_store[k_reg]  <= new_low;
                if (!hit)
                begin
                    start_store[k_reg] <= floored_reg;
                    open_store[k_reg]  <= price;
                    fvol_store[k_reg]  <= item_reg.dvol;
                    foi_store[k_reg]   <= item_reg.doi;
                end
            end
        end
    end

    assign bar.valid            = (state_reg == S_OUT);
    assign bar.frame_index      = o_frame_reg;
    assign bar.bar_time_ms      = o_time_reg;
    assign bar.bar_open         = o_open_reg;
    assign bar.bar_high         = o_high_reg;
    assign bar.bar_low          = o_low_reg;
    assign bar.bar_close        = o_close_reg;
    assign bar.bar_average      = o_avg_reg;
    assign bar.bar_direction    = o_dir_reg;
    assign bar.delta_volume     = o_dvol_reg;
    assign bar.delta_interest   = o_doi_reg;
    assign bar.close_minus_open = o_com_reg;
    assign bar.last_of_run      = o_last_reg;

    `TTA_ASSERT_IMP(a_valid_only_out, clk, rst_n, bar.valid, state_reg == S_OUT)
    `TTA_ASSERT_IMP(a_last_flag, clk, rst_n, bar.valid && bar.last_of_run, bar.frame_index == 2'(FRAMES - 1))
    `TTA_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, k_sel == '0)
    `TTA_ASSERT_NXT(a_stall_hold, clk, rst_n, bar.valid && !bar.ready, bar.valid && $stable(o_avg_reg))
endmodule
